// ===== hdl/fbic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbic_pkg
// Shared constants and types for the flash block image checker: block size,
// magic values, status codes and the result record.
// ----------------------------------------------------------------------------
package fbic_pkg;

  // block geometry
  localparam int BlockBytes = 1024;
  localparam int PosW       = $clog2(BlockBytes);

  // magic values
  localparam logic [23:0] HeaderMagic = 24'hCAFEBA;
  localparam logic [7:0]  TailMagic   = 8'hBE;
  localparam logic [7:0]  SumTarget   = 8'hFF;

  // size limit, wide enough for the largest block size
  localparam logic [23:0] SizeLimit = 24'(BlockBytes);

  // result stream packing
  localparam int OutDataW = 16;

  // status codes, in check priority order
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_TAIL   = 3'd2,
    ST_NAME_BIG   = 3'd3,
    ST_DATA_BIG   = 3'd4,
    ST_BAD_SUM    = 3'd5
  } status_t;

  // one result record
  typedef struct packed {
    logic        is_empty;
    logic [7:0]  seal_byte;
    status_t     status;
  } result_t;

endpackage

// ===== hdl/flash_block_image_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_block_image_checker
// Validates a streamed flash block image: header, tail, record sizes and
// byte sum, and computes the seal byte that makes the block sum to 0xFF.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte of the block per request, in address order.
//   out_* : one request per block, issued after the block's last byte:
//           status, seal byte and empty flag.
//   Bytes are taken one per cycle, back to back, except while a block's last
//   byte waits for a busy output register. A byte is held in the input
//   register, then updates the counter and sums; the last byte of a block
//   loads its result into the output register, from which it is issued.
//   Throughput is one byte per cycle outside such a stall, set by the
//   update of the running sums and capture registers.
//   When the receiver stalls, the result holds in the output register and
//   bytes inside the next block keep flowing; only the next block's last
//   byte waits in the input register until the output register is free.
//   Reset (synchronous, active low) empties both registers and restarts at
//   byte 0 of a new block.
// ----------------------------------------------------------------------------
module flash_block_image_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [2:0] status, [10:3] seal_byte, [11] is_empty
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                out_valid_r, out_valid_nxt;
  fbic_pkg::result_t   out_res_r;

  logic                step;
  logic                last_byte;
  fbic_pkg::result_t   result;

  // byte processing
  fbic_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last_byte (last_byte),
    .result    (result)
  );

  // held byte moves on unless it needs a busy output register
  assign step      = in_valid_r && (!last_byte || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (step && last_byte) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last_byte) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(fbic_pkg::OutDataW - $bits(fbic_pkg::result_t))'(0), out_res_r};

  // input side only stalls on a waiting last byte
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && last_byte && out_valid_r && !out_tready)
    else $error("input stalled without a blocked result");

  // a finished block always lands in the output register
  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> out_valid_r)
    else $error("block result lost");

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(step && last_byte))
    else $error("pending result overwritten");

endmodule

// ===== hdl/fbic_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbic_core
// Running byte counter, the two 8-bit sums and the header / record capture.
// Flags the last byte of a block and forms its result combinationally.
// ----------------------------------------------------------------------------
module fbic_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,       // consume data_byte this cycle
  input  logic [7:0]           data_byte,
  output logic                 last_byte,  // data_byte closes the block
  output fbic_pkg::result_t    result
);

  logic [fbic_pkg::PosW-1:0] pos_r,    pos_nxt;
  logic [7:0]                total_r,  total_nxt;
  logic [7:0]                seal_r,   seal_nxt;
  logic [23:0]               header_r, header_nxt;
  logic [31:0]               record_r, record_nxt;

  logic [7:0]                total_sum;
  logic [7:0]                seal_sum;
  logic [7:0]                name_len;
  logic [22:0]               data_len;

  assign last_byte = (pos_r == fbic_pkg::PosW'(fbic_pkg::BlockBytes - 1));

  // sums including the byte at hand; byte 3 is left out of the seal sum
  assign total_sum = total_r + data_byte;
  assign seal_sum  = (pos_r == fbic_pkg::PosW'(3)) ? seal_r : seal_r + data_byte;

  // record word fields
  assign name_len = record_r[7:0];
  assign data_len = record_r[30:8];

  // next state: capture header and record bytes, clear after the last byte
  always_comb begin
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    seal_nxt   = seal_r;
    header_nxt = header_r;
    record_nxt = record_r;
    if (step) begin
      if (last_byte) begin
        pos_nxt    = '0;
        total_nxt  = '0;
        seal_nxt   = '0;
        header_nxt = '0;
        record_nxt = '0;
      end else begin
        pos_nxt   = pos_r + fbic_pkg::PosW'(1);
        total_nxt = total_sum;
        seal_nxt  = seal_sum;
        if (pos_r == fbic_pkg::PosW'(0)) header_nxt[7:0]   = data_byte;
        if (pos_r == fbic_pkg::PosW'(1)) header_nxt[15:8]  = data_byte;
        if (pos_r == fbic_pkg::PosW'(2)) header_nxt[23:16] = data_byte;
        if (pos_r == fbic_pkg::PosW'(4)) record_nxt[7:0]   = data_byte;
        if (pos_r == fbic_pkg::PosW'(5)) record_nxt[15:8]  = data_byte;
        if (pos_r == fbic_pkg::PosW'(6)) record_nxt[23:16] = data_byte;
        if (pos_r == fbic_pkg::PosW'(7)) record_nxt[31:24] = data_byte;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      total_r  <= '0;
      seal_r   <= '0;
      header_r <= '0;
      record_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      seal_r   <= seal_nxt;
      header_r <= header_nxt;
      record_r <= record_nxt;
    end
  end

  // block checks in priority order
  always_comb begin
    if (header_r != fbic_pkg::HeaderMagic)
      result.status = fbic_pkg::ST_BAD_HEADER;
    else if (data_byte != fbic_pkg::TailMagic)
      result.status = fbic_pkg::ST_BAD_TAIL;
    else if ({16'd0, name_len} > fbic_pkg::SizeLimit)
      result.status = fbic_pkg::ST_NAME_BIG;
    else if ({1'b0, data_len} > fbic_pkg::SizeLimit)
      result.status = fbic_pkg::ST_DATA_BIG;
    else if (total_sum != fbic_pkg::SumTarget)
      result.status = fbic_pkg::ST_BAD_SUM;
    else
      result.status = fbic_pkg::ST_OK;
    result.seal_byte = fbic_pkg::SumTarget - seal_sum;
    result.is_empty  = (name_len == 8'd0);
  end

  // counter never leaves the block
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= fbic_pkg::PosW'(fbic_pkg::BlockBytes - 1))
    else $error("byte counter beyond block end");

  // counter advances by one on each byte inside a block
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last_byte |=> pos_r == $past(pos_r) + fbic_pkg::PosW'(1))
    else $error("byte counter did not advance");

  // block end restarts all running state
  a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_byte |=> pos_r == '0 && total_r == '0 && seal_r == '0
      && header_r == '0 && record_r == '0)
    else $error("state not cleared after block end");

endmodule
